// File: rtl/core/rras_pkg.sv
// Shared types and codes for the round-robin slot allocator.
`timescale 1ns / 1ps

package rras_pkg;

    localparam int CFG_W    = 6;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 2;

    localparam logic CMD_LOCK    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_GRANTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_IDX  = 2'd3;

    // broadcast controls for the cell row
    typedef struct packed {
        logic scan;   // token marks its cell busy
        logic shift;  // token moves one cell on
        logic flush;  // token removed
    } t_cell_ctl;

endpackage

// File: rtl/core/rras_cell.sv
// One slot cell: busy mark plus a search token passed to the next cell.
`timescale 1ns / 1ps

module rras_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rras_pkg::t_cell_ctl i_ctl,
    input  logic                i_load,
    input  logic                i_release,
    input  logic                i_token,
    output logic                o_token,
    output logic                o_busy,
    output logic                o_hit
);
    import rras_pkg::*;

    logic r_busy;
    logic r_token;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_token <= 1'b0;
        end else begin
            if (i_release) begin
                r_busy <= 1'b0;
            end else if (i_ctl.scan && r_token) begin
                r_busy <= 1'b1;
            end

            if (i_load) begin
                r_token <= 1'b1;
            end else if (i_ctl.flush) begin
                r_token <= 1'b0;
            end else if (i_ctl.shift) begin
                r_token <= i_token;
            end
        end
    end

    assign o_token = r_token;
    assign o_busy  = r_busy;
    assign o_hit   = r_token & ~r_busy;

endmodule

// File: rtl/core/round_robin_slot_allocator.sv
// Top level: round-robin free-slot allocator built on a row of slot cells.
`timescale 1ns / 1ps
//
// Requests arrive on the s_axis channel: tuser[0] is the command (lock or
// release), tdata[4:0] the slot to release. Each request gives one response
// on m_axis: tuser[1:0] is the status, tdata[4:0] the granted slot.
// i_cfg_we/i_cfg_wdata write the active slot count; write it only while idle.
//
// A lock drops a search token into the cell at the start pointer; the token
// hops one cell per cycle along the active slots, wrapping, until it sits on
// a free cell or has visited every active slot. A lock response goes from
// the scan to the pending register and then to the output register; a
// release response skips the scan. One request is in flight at a time; the
// next is accepted once the response has moved to the output register, even
// if the receiver has not taken it yet.
// Reset (i_rst_n low, synchronous) frees every slot, zeroes the start
// pointer and sets the active count to 32. If m_axis_tready is low the
// response holds; a finished next response waits inside until it drains.

module round_robin_slot_allocator #(
    parameter int SLOTS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rras_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,  // [4:0] release_index
    input  logic [0:0]                s_axis_tuser,  // [0] command
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,  // [4:0] slot_index
    output logic [1:0]                m_axis_tuser   // [1:0] status
);
    import rras_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int NW = ($clog2(SLOTS + 1) > CFG_W) ? $clog2(SLOTS + 1) : CFG_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DELIVER} t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_active;
    logic [IW-1:0]        r_ptr;
    logic [IW-1:0]        r_pos;
    logic [NW-1:0]        r_left;
    logic [STATUS_W-1:0]  r_pend_status;
    logic [SLOT_W-1:0]    r_pend_idx;
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic [SLOT_W-1:0]    r_out_idx;

    logic [NW-1:0]        w_act;
    logic [NW-1:0]        w_n;
    logic [NW-1:0]        w_n_m1;
    logic [IW-1:0]        w_last;
    logic [IW-1:0]        w_start;
    logic [NW-1:0]        w_pos_ext;
    logic [NW-1:0]        w_pos_inc;
    logic [IW-1:0]        n_pos;
    logic [SLOT_W-1:0]    w_rel;
    logic                 w_rel_ok;
    logic                 w_accept;
    logic                 w_cmd;
    logic                 w_any_hit;
    logic                 w_tok_wrap;
    logic                 w_deliver;
    t_cell_ctl            w_ctl;
    logic [SLOTS-1:0]     w_tok;
    logic [SLOTS-1:0]     w_busy;
    logic [SLOTS-1:0]     w_hit;

    // effective slot count: zero acts as one, clamp at SLOTS
    assign w_act  = NW'(r_active);
    assign w_n    = (r_active == '0) ? NW'(1) :
                    (w_act > NW'(SLOTS)) ? NW'(SLOTS) : w_act;
    assign w_n_m1 = w_n - NW'(1);
    assign w_last = w_n_m1[IW-1:0];
    assign w_start = (NW'(r_ptr) < w_n) ? r_ptr : '0;

    assign w_pos_ext = NW'(r_pos);
    assign w_pos_inc = w_pos_ext + NW'(1);
    assign n_pos     = (w_pos_inc >= w_n) ? '0 : w_pos_inc[IW-1:0];

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_cmd    = s_axis_tuser[0];
    assign w_rel    = s_axis_tdata[SLOT_W-1:0];
    assign w_rel_ok = NW'(w_rel) < w_n;

    assign w_any_hit  = |w_hit;
    assign w_tok_wrap = w_tok[w_last];

    // pending response moves to the output register
    assign w_deliver = (r_state == S_DELIVER) && (!r_out_valid || m_axis_tready);

    always_comb begin
        w_ctl.scan  = (r_state == S_SCAN);
        w_ctl.shift = (r_state == S_SCAN) && !w_any_hit && (r_left != NW'(1));
        w_ctl.flush = (r_state == S_SCAN) && !w_ctl.shift;
    end

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        logic w_tok_in;
        logic w_load;
        logic w_release;

        if (i == 0) begin : g_head
            assign w_tok_in = w_tok_wrap;
        end else begin : g_body
            assign w_tok_in = w_tok[i-1] & (NW'(i) < w_n);
        end

        assign w_load    = w_accept && (w_cmd == CMD_LOCK) && (w_start == IW'(i));
        assign w_release = w_accept && (w_cmd == CMD_RELEASE) && w_rel_ok
                           && (NW'(w_rel) == NW'(i));

        rras_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_load    (w_load),
            .i_release (w_release),
            .i_token   (w_tok_in),
            .o_token   (w_tok[i]),
            .o_busy    (w_busy[i]),
            .o_hit     (w_hit[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= CFG_W'(32);
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end

            if (w_deliver) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_cmd == CMD_LOCK) begin
                            r_pos   <= w_start;
                            r_left  <= w_n;
                            r_state <= S_SCAN;
                        end else begin
                            r_pend_status <= w_rel_ok ? ST_RELEASED : ST_BAD_IDX;
                            r_pend_idx    <= '0;
                            r_state       <= S_DELIVER;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_any_hit) begin
                        r_pend_status <= ST_GRANTED;
                        r_pend_idx    <= w_pos_ext[SLOT_W-1:0];
                        r_ptr         <= n_pos;
                        r_state       <= S_DELIVER;
                    end else if (r_left == NW'(1)) begin
                        r_pend_status <= ST_NONE;
                        r_pend_idx    <= '0;
                        r_state       <= S_DELIVER;
                    end else begin
                        r_pos  <= n_pos;
                        r_left <= r_left - NW'(1);
                    end
                end
                S_DELIVER: begin
                    if (w_deliver) begin
                        r_out_status <= r_pend_status;
                        r_out_idx    <= r_pend_idx;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(8 - SLOT_W){1'b0}}, r_out_idx};
    assign m_axis_tuser  = r_out_status;

    // at most one search token in the row
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one search token in the cell row");

    // tokens live only while scanning
    a_token_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) |-> (w_tok == '0))
        else $error("search token outside a scan");

    // a grant marks exactly one newly busy slot
    a_grant_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_any_hit) |=> $onehot(w_busy & ~$past(w_busy)))
        else $error("grant did not mark exactly one slot busy");

    // scan budget never runs out while scanning
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_left != '0))
        else $error("scan with no slots left to visit");

endmodule
